@@ hdl/orct_pkg.sv @@
package orct_pkg;

  // CORDIC depth and the length of the arctangent table
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // Working widths
  localparam int ZW  = 35;  // angle, Q30 radians
  localparam int CSW = 34;  // cos / sin, Q30
  localparam int PW  = 66;  // size times cos / sin
  localparam int CW  = 36;  // corner coordinate, Q16.16
  localparam int DW  = 37;  // difference of two corners
  localparam int MW  = 56;  // partial product, difference times half a difference
  localparam int XW  = 75;  // full cross product term
  localparam int SPLIT = 18; // low half width of the split multiplier operand

  localparam logic signed [ZW-1:0]  Q30_PI      = 35'sd3373259426;
  localparam logic signed [ZW-1:0]  Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [CSW-1:0] Q30_GAIN    = 34'sd652032874;
  localparam logic signed [PW-1:0]  RND_HALF    = {{(PW-31){1'b0}}, 1'b1, 30'd0};

  // Truncated Q30 atan(2^-i)
  localparam logic [30:0] ATAN_Q30 [ATAN_LEN] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255, 31'd127
  };

  // Hit kind codes
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_A_IN_B = 2'd1;
  localparam logic [1:0] KIND_B_IN_A = 2'd2;

  typedef logic signed [CSW-1:0] trig_t;
  typedef logic signed [CW-1:0]  coord_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        len;
    logic [30:0]        wid;
  } geom_t;

  // Corners counter-clockwise: +x+y, -x+y, -x-y, +x-y
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } corners_t;

  typedef struct packed {
    logic [3:0] a_in_b;
    logic [3:0] b_in_a;
  } hits_t;

endpackage

@@ hdl/orct_in_if.sv @@
interface orct_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_center_x;
  logic signed [31:0] a_center_y;
  logic signed [15:0] a_heading;
  logic [30:0]        a_length;
  logic [30:0]        a_width;
  logic signed [31:0] b_center_x;
  logic signed [31:0] b_center_y;
  logic signed [15:0] b_heading;
  logic [30:0]        b_length;
  logic [30:0]        b_width;

  modport source (
    output valid, a_center_x, a_center_y, a_heading, a_length, a_width,
           b_center_x, b_center_y, b_heading, b_length, b_width,
    input  ready
  );
  modport sink (
    input  valid, a_center_x, a_center_y, a_heading, a_length, a_width,
           b_center_x, b_center_y, b_heading, b_length, b_width,
    output ready
  );
endinterface

@@ hdl/orct_out_if.sv @@
interface orct_out_if;
  logic       valid;
  logic       ready;
  logic       collide;
  logic [1:0] hit_kind;

  modport source (output valid, collide, hit_kind, input ready);
  modport sink (input valid, collide, hit_kind, output ready);
endinterface

@@ hdl/orct_cordic.sv @@
module orct_cordic #(
  parameter int STEPS = orct_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [15:0] heading,
  output orct_pkg::trig_t    cos_q,
  output orct_pkg::trig_t    sin_q
);
  import orct_pkg::*;

  logic signed [ZW-1:0] z_in;
  logic signed [ZW-1:0] z_r [0:STEPS];
  trig_t                c_r [0:STEPS];
  trig_t                s_r [0:STEPS];
  logic                 flip_r [0:STEPS];
  trig_t                cos_r;
  trig_t                sin_r;

  // Q3.13 heading to Q30 angle
  assign z_in = {{(ZW-33){heading[15]}}, heading, 17'd0};

  // Fold the angle into +-pi/2, note the flip
  always_ff @(posedge clk) begin
    if (adv) begin
      if (z_in > Q30_HALF_PI) begin
        z_r[0]    <= z_in - Q30_PI;
        flip_r[0] <= 1'b1;
      end else if (z_in < -Q30_HALF_PI) begin
        z_r[0]    <= z_in + Q30_PI;
        flip_r[0] <= 1'b1;
      end else begin
        z_r[0]    <= z_in;
        flip_r[0] <= 1'b0;
      end
      c_r[0] <= Q30_GAIN;
      s_r[0] <= '0;
    end
  end

  // One rotation step per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] T = ZW'(ATAN_Q30[i]);
    trig_t                dc;
    trig_t                ds;
    trig_t                c_nxt;
    trig_t                s_nxt;
    logic signed [ZW-1:0] z_nxt;

    assign dc = s_r[i] >>> i;
    assign ds = c_r[i] >>> i;

    always_comb begin
      if (!z_r[i][ZW-1]) begin
        c_nxt = c_r[i] - dc;
        s_nxt = s_r[i] + ds;
        z_nxt = z_r[i] - T;
      end else begin
        c_nxt = c_r[i] + dc;
        s_nxt = s_r[i] - ds;
        z_nxt = z_r[i] + T;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c_r[i+1]    <= c_nxt;
        s_r[i+1]    <= s_nxt;
        z_r[i+1]    <= z_nxt;
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  // Undo the fold
  always_ff @(posedge clk) begin
    if (adv) begin
      cos_r <= flip_r[STEPS] ? -c_r[STEPS] : c_r[STEPS];
      sin_r <= flip_r[STEPS] ? -s_r[STEPS] : s_r[STEPS];
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

@@ hdl/orct_corners.sv @@
module orct_corners (
  input  logic              clk,
  input  logic              adv,
  input  orct_pkg::trig_t   cos_q,
  input  orct_pkg::trig_t   sin_q,
  input  orct_pkg::geom_t   geom,
  output orct_pkg::corners_t corners
);
  import orct_pkg::*;

  logic signed [PW-1:0] lc_r;
  logic signed [PW-1:0] ls_r;
  logic signed [PW-1:0] wc_r;
  logic signed [PW-1:0] ws_r;
  logic signed [31:0]   cx_r;
  logic signed [31:0]   cy_r;
  corners_t             corners_r;
  corners_t             corners_nxt;

  // Size times cos and sin
  always_ff @(posedge clk) begin
    if (adv) begin
      lc_r <= $signed({1'b0, geom.len}) * cos_q;
      ls_r <= $signed({1'b0, geom.len}) * sin_q;
      wc_r <= $signed({1'b0, geom.wid}) * cos_q;
      ws_r <= $signed({1'b0, geom.wid}) * sin_q;
      cx_r <= geom.cx;
      cy_r <= geom.cy;
    end
  end

  // Signed offsets, round to Q16.16, add the center
  for (genvar k = 0; k < 4; k++) begin : g_corner
    localparam bit SGX = (k == 0) || (k == 3);
    localparam bit SGY = (k < 2);
    logic signed [PW-1:0] dx;
    logic signed [PW-1:0] dy;
    logic signed [PW-1:0] rx;
    logic signed [PW-1:0] ry;

    assign dx = (SGX ? lc_r : -lc_r) - (SGY ? ws_r : -ws_r);
    assign dy = (SGX ? ls_r : -ls_r) + (SGY ? wc_r : -wc_r);
    assign rx = (dx + RND_HALF) >>> 31;
    assign ry = (dy + RND_HALF) >>> 31;
    assign corners_nxt.x[k] = CW'(rx) + CW'(cx_r);
    assign corners_nxt.y[k] = CW'(ry) + CW'(cy_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      corners_r <= corners_nxt;
    end
  end

  assign corners = corners_r;

endmodule

@@ hdl/orct_contain.sv @@
module orct_contain (
  input  logic               clk,
  input  logic               adv,
  input  orct_pkg::corners_t ca,
  input  orct_pkg::corners_t cb,
  output orct_pkg::hits_t    hits
);
  import orct_pkg::*;

  // Owner 0 is B tested with the A corners, owner 1 is A tested with the B corners
  corners_t own [2];
  corners_t pts [2];

  logic signed [DW-1:0] ex_r [2][4];
  logic signed [DW-1:0] ey_r [2][4];
  logic signed [DW-1:0] dx_r [2][4][4];
  logic signed [DW-1:0] dy_r [2][4][4];
  logic signed [MW-1:0] ph_r [2][4][4];
  logic signed [MW-1:0] pl_r [2][4][4];
  logic signed [MW-1:0] qh_r [2][4][4];
  logic signed [MW-1:0] ql_r [2][4][4];
  logic signed [XW-1:0] p_r  [2][4][4];
  logic signed [XW-1:0] q_r  [2][4][4];
  logic [3:0]           in_nxt [2];
  hits_t                hits_r;

  assign own[0] = cb;
  assign pts[0] = ca;
  assign own[1] = ca;
  assign pts[1] = cb;

  for (genvar o = 0; o < 2; o++) begin : g_own
    for (genvar i = 0; i < 4; i++) begin : g_edge
      localparam int J = (i + 1) % 4;

      // Edge vectors
      always_ff @(posedge clk) begin
        if (adv) begin
          ex_r[o][i] <= DW'($signed(own[o].x[J])) - DW'($signed(own[o].x[i]));
          ey_r[o][i] <= DW'($signed(own[o].y[J])) - DW'($signed(own[o].y[i]));
        end
      end

      for (genvar p = 0; p < 4; p++) begin : g_pt
        logic signed [XW-1:0] diff;

        // Point relative to the edge start, then split products, sums, sign
        always_ff @(posedge clk) begin
          if (adv) begin
            dx_r[o][p][i] <= DW'($signed(pts[o].x[p])) - DW'($signed(own[o].x[i]));
            dy_r[o][p][i] <= DW'($signed(pts[o].y[p])) - DW'($signed(own[o].y[i]));
            ph_r[o][p][i] <= ex_r[o][i] * $signed(dy_r[o][p][i][DW-1:SPLIT]);
            pl_r[o][p][i] <= ex_r[o][i] * $signed({1'b0, dy_r[o][p][i][SPLIT-1:0]});
            qh_r[o][p][i] <= dx_r[o][p][i] * $signed(ey_r[o][i][DW-1:SPLIT]);
            ql_r[o][p][i] <= dx_r[o][p][i] * $signed({1'b0, ey_r[o][i][SPLIT-1:0]});
            p_r[o][p][i]  <= (XW'(ph_r[o][p][i]) <<< SPLIT) + XW'(pl_r[o][p][i]);
            q_r[o][p][i]  <= (XW'(qh_r[o][p][i]) <<< SPLIT) + XW'(ql_r[o][p][i]);
          end
        end

        assign diff = p_r[o][p][i] - q_r[o][p][i];
      end
    end

    // A point is inside when no edge sees it on the right
    for (genvar p = 0; p < 4; p++) begin : g_in
      assign in_nxt[o][p] = !g_edge[0].g_pt[p].diff[XW-1] && !g_edge[1].g_pt[p].diff[XW-1]
                         && !g_edge[2].g_pt[p].diff[XW-1] && !g_edge[3].g_pt[p].diff[XW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hits_r.a_in_b <= in_nxt[0];
      hits_r.b_in_a <= in_nxt[1];
    end
  end

  assign hits = hits_r;

endmodule

@@ hdl/oriented_rectangle_collision_test_core.sv @@
// Channel   Dir  Contents
// in_chan   in   two rectangles: center, heading, length, width each
// out_chan  out  collide flag and hit kind
//
// One pair enters per cycle unless the output stalls; a result leaves after the CORDIC, corner and containment stages.
// The depth is set by the CORDIC chain, one rotation step per stage.
// Reset clears the stage valid bits and the output valid bit.
// When the output register holds a result that is not taken, every stage holds.
module oriented_rectangle_collision_test_core #(
  parameter int CORDIC_STEPS = orct_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  orct_in_if.sink    in_chan,
  orct_out_if.source out_chan
);
  import orct_pkg::*;

  localparam int GEO_DLY = CORDIC_STEPS + 2;
  localparam int LAT     = GEO_DLY + 6;

  logic       adv;
  logic       vld_r [0:LAT-1];
  logic       out_valid_r;
  logic       collide_r;
  logic [1:0] kind_r;
  logic [1:0] kind_nxt;

  geom_t    geo_a_r [0:GEO_DLY-1];
  geom_t    geo_b_r [0:GEO_DLY-1];
  trig_t    cos_a, sin_a, cos_b, sin_b;
  corners_t corn_a, corn_b;
  hits_t    hits;

  // Advance whenever the output register is free or being emptied
  assign adv          = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // Carry centers and sizes beside the CORDIC
  always_ff @(posedge clk) begin
    if (adv) begin
      geo_a_r[0] <= '{cx: in_chan.a_center_x, cy: in_chan.a_center_y,
                      len: in_chan.a_length, wid: in_chan.a_width};
      geo_b_r[0] <= '{cx: in_chan.b_center_x, cy: in_chan.b_center_y,
                      len: in_chan.b_length, wid: in_chan.b_width};
      for (int k = 1; k < GEO_DLY; k++) begin
        geo_a_r[k] <= geo_a_r[k-1];
        geo_b_r[k] <= geo_b_r[k-1];
      end
    end
  end

  orct_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
    .clk(clk), .adv(adv), .heading(in_chan.a_heading), .cos_q(cos_a), .sin_q(sin_a)
  );
  orct_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_b (
    .clk(clk), .adv(adv), .heading(in_chan.b_heading), .cos_q(cos_b), .sin_q(sin_b)
  );

  orct_corners u_corners_a (
    .clk(clk), .adv(adv), .cos_q(cos_a), .sin_q(sin_a),
    .geom(geo_a_r[GEO_DLY-1]), .corners(corn_a)
  );
  orct_corners u_corners_b (
    .clk(clk), .adv(adv), .cos_q(cos_b), .sin_q(sin_b),
    .geom(geo_b_r[GEO_DLY-1]), .corners(corn_b)
  );

  orct_contain u_contain (
    .clk(clk), .adv(adv), .ca(corn_a), .cb(corn_b), .hits(hits)
  );

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_chan.valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // A corner of A inside B takes priority
  always_comb begin
    if (|hits.a_in_b) begin
      kind_nxt = KIND_A_IN_B;
    end else if (|hits.b_in_a) begin
      kind_nxt = KIND_B_IN_A;
    end else begin
      kind_nxt = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      collide_r <= (|hits.a_in_b) || (|hits.b_in_a);
      kind_r    <= kind_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.collide  = collide_r;
  assign out_chan.hit_kind = kind_r;

endmodule
